FILE: design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, types and controller/datapath command structs for the
// SSIM window metric.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_SIDE = 16;
  localparam int MAX_WINDOWS = 1048576;
  localparam int MAX_PIX     = WINDOW_SIDE * WINDOW_SIDE;
  localparam int CNT_W       = $clog2(MAX_PIX + 1);
  localparam int SUM_W       = 8 + CNT_W;
  localparam int SQ_W        = 16 + CNT_W;
  localparam int WCNT_W      = $clog2(MAX_WINDOWS + 1);
  localparam int TOT_W       = 18 + WCNT_W;

  localparam logic [14:0] C1_X400 = 15'd2601;
  localparam logic [14:0] C2_X400 = 15'd23409;
  localparam logic [16:0] Q16_ONE = 17'd65536;

  // division unit widths: numerator and denominator up to ~2^50
  localparam int DIV_W = 64;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  typedef enum logic [3:0] {
    ST_ACC,     // accumulating pixels
    ST_MEAN,    // dividing the five window sums by the count
    ST_TERM1,   // products of means
    ST_TERM2,   // numerator/denominator terms
    ST_PROD,    // num and den products
    ST_RATIO,   // long division num/den
    ST_FRAC,    // fraction bits and saturation
    ST_COMP,    // component mean divide
    ST_OUT      // result waiting on the output
  } swm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic acc;        // accumulate the accepted pixel
    logic mean_start; // start the sum/count divisions
    logic term1;
    logic term2;
    logic prod;
    logic ratio_start;
    logic frac;
    logic comp_start;
    logic out_load;
    logic out_clear;
  } swm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } swm_sts_t;

endpackage

FILE: design/swm_div.sv
// ----------------------------------------------------------------------------
// swm_div
// Restoring divider, one quotient bit per cycle, unsigned DIV_W bits.
// ----------------------------------------------------------------------------
module swm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swm_pkg::DIV_W-1:0]  num,
  input  logic [swm_pkg::DIV_W-1:0]  den,
  output logic                       done,
  output logic [swm_pkg::DIV_W-1:0]  quo,
  output logic [swm_pkg::DIV_W-1:0]  rem
);

  logic [swm_pkg::DIV_W-1:0]  q_r, q_nxt;
  logic [swm_pkg::DIV_W:0]    r_r, r_nxt;
  logic [swm_pkg::DIV_W-1:0]  d_r, d_nxt;
  logic [swm_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [swm_pkg::DIV_W:0]    trial;

  // one shift-subtract step per cycle
  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r[swm_pkg::DIV_W-1:0], q_r[swm_pkg::DIV_W-1]};
    if (start) begin
      q_nxt    = num;
      r_nxt    = '0;
      d_nxt    = den;
      cnt_nxt  = swm_pkg::DIV_CW'(swm_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[swm_pkg::DIV_W-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[swm_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == swm_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[swm_pkg::DIV_W-1:0];

endmodule

FILE: design/swm_datapath.sv
// ----------------------------------------------------------------------------
// swm_datapath
// Window accumulators, SSIM term arithmetic, shared divider, component total
// and the output register.
// ----------------------------------------------------------------------------
module swm_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::swm_cmd_t   cmd,
  output swm_pkg::swm_sts_t   sts,
  input  logic [7:0]          pixel_ref,
  input  logic [7:0]          pixel_test,
  input  logic                component_end,
  output logic [39:0]         out_word
);

  localparam int W = swm_pkg::DIV_W;

  // window accumulators
  logic [swm_pkg::SUM_W-1:0] sr_r, st_r;
  logic [swm_pkg::SQ_W-1:0]  qr_r, qt_r, qc_r;
  logic [swm_pkg::CNT_W-1:0] cnt_r;
  logic                      cend_r;

  // terms
  logic [8:0]          a1_r, a2_r;
  logic [16:0]         m1_r, m2_r, mc_r;
  logic [2:0]          mean_idx_r;
  logic                mean_busy_r;
  logic [16:0]         a11_r, a22_r, a12_r;
  logic signed [31:0]  ta_r, tb_r, tc_r, te_r;
  logic [W-1:0]        num_r, den_r;
  logic                neg_r;
  logic signed [17:0]  w_r;
  logic signed [swm_pkg::TOT_W-1:0]  tot_r;
  logic [swm_pkg::WCNT_W-1:0]        wcnt_r;
  logic signed [17:0]  comp_r;
  logic                comp_busy_r;
  logic                tot_neg_r;
  logic [39:0]         out_r;

  // shared divider
  logic         div_start;
  logic [W-1:0] div_num, div_den, div_q, div_r;
  logic         div_done;

  swm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q),
    .rem  (div_r)
  );

  // divider operand selection
  logic [W-1:0] mean_sel;
  logic [W-1:0] tot_mag;
  logic [W-1:0] tot_ext;
  logic         mean_next;
  always_comb begin
    unique case (mean_idx_r)
      3'd0:    mean_sel = W'(sr_r);
      3'd1:    mean_sel = W'(st_r);
      3'd2:    mean_sel = W'(qr_r);
      3'd3:    mean_sel = W'(qt_r);
      default: mean_sel = W'(qc_r);
    endcase
    tot_ext = W'($unsigned(tot_r));
    tot_mag = tot_r[swm_pkg::TOT_W-1] ? W'($unsigned(-tot_r)) : W'($unsigned(tot_r));
    if (tot_r[swm_pkg::TOT_W-1]) tot_mag = W'(-$signed(tot_ext)) &
                                           W'({swm_pkg::TOT_W{1'b1}});
    mean_next = mean_busy_r && div_done && (mean_idx_r != 3'd5);
    div_start = cmd.mean_start || mean_next || cmd.ratio_start || cmd.comp_start;
    if (cmd.ratio_start) begin
      div_num = num_r;
      div_den = den_r;
    end else if (cmd.comp_start) begin
      div_num = tot_mag;
      div_den = (wcnt_r == '0) ? W'(1) : W'(wcnt_r);
    end else begin
      div_num = cmd.mean_start ? W'(sr_r) : mean_sel;
      div_den = W'(cnt_r);
    end
  end

  // accumulation and mean collection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sr_r        <= '0;
      st_r        <= '0;
      qr_r        <= '0;
      qt_r        <= '0;
      qc_r        <= '0;
      mean_busy_r <= 1'b0;
      mean_idx_r  <= '0;
    end else begin
      if (cmd.acc) begin
        cend_r <= component_end;
        if (cnt_r < swm_pkg::CNT_W'(swm_pkg::MAX_PIX)) begin
          sr_r  <= sr_r + swm_pkg::SUM_W'(pixel_ref);
          st_r  <= st_r + swm_pkg::SUM_W'(pixel_test);
          qr_r  <= qr_r + swm_pkg::SQ_W'(pixel_ref * pixel_ref);
          qt_r  <= qt_r + swm_pkg::SQ_W'(pixel_test * pixel_test);
          qc_r  <= qc_r + swm_pkg::SQ_W'(pixel_ref * pixel_test);
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.mean_start) begin
        mean_busy_r <= 1'b1;
        mean_idx_r  <= 3'd1;
      end else if (mean_busy_r && div_done) begin
        unique case (mean_idx_r)
          3'd1:    a1_r <= div_q[8:0];
          3'd2:    a2_r <= div_q[8:0];
          3'd3:    m1_r <= div_q[16:0];
          3'd4:    m2_r <= div_q[16:0];
          default: mc_r <= div_q[16:0];
        endcase
        if (mean_idx_r == 3'd5) begin
          mean_busy_r <= 1'b0;
          // window state clears once sums are consumed
          cnt_r <= '0;
          sr_r  <= '0;
          st_r  <= '0;
          qr_r  <= '0;
          qt_r  <= '0;
          qc_r  <= '0;
        end else begin
          mean_idx_r <= mean_idx_r + 1'b1;
        end
      end
    end
  end

  // term arithmetic
  logic signed [31:0] v1, v2, cov, tb_mag, te_c;
  always_comb begin
    v1     = $signed({15'd0, m1_r}) - $signed({15'd0, a11_r});
    v2     = $signed({15'd0, m2_r}) - $signed({15'd0, a22_r});
    cov    = $signed({15'd0, mc_r}) - $signed({15'd0, a12_r});
    tb_mag = tb_r[31] ? -tb_r : tb_r;
    te_c   = (te_r < 32'sd1) ? 32'sd1 : te_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.term1) begin
      a11_r <= 17'(a1_r * a1_r);
      a22_r <= 17'(a2_r * a2_r);
      a12_r <= 17'(a1_r * a2_r);
    end
    if (cmd.term2) begin
      ta_r <= $signed(32'(a12_r) * 32'd800) + 32'sd2601;
      tb_r <= cov * 32'sd800 + 32'sd23409;
      tc_r <= $signed((32'(a11_r) + 32'(a22_r)) * 32'd400) + 32'sd2601;
      te_r <= (v1 + v2) * 32'sd400 + 32'sd23409;
    end
    if (cmd.prod) begin
      num_r <= W'($unsigned(ta_r)) * W'($unsigned(tb_mag));
      den_r <= W'($unsigned(tc_r)) * W'($unsigned(te_c));
      neg_r <= tb_r[31];
    end
  end

  // fraction: remainder r < den, next 16 bits are (r<<16)/den; reuse divider
  // by running a second pass is avoided: q<=1 so compute with one more pass
  logic         frac_busy_r;
  logic [1:0]   ratio_q_r;
  logic [4:0]   fcnt_r;
  logic [W:0]   frem_r;
  logic [16:0]  fq_r;
  logic         frac_done_r;
  logic [W:0]   ftrial;
  always_comb ftrial = {frem_r[W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_busy_r <= 1'b0;
      frac_done_r <= 1'b0;
      fcnt_r      <= '0;
    end else begin
      frac_done_r <= 1'b0;
      if (cmd.frac) begin
        frac_busy_r <= 1'b1;
        fcnt_r      <= 5'd16;
        frem_r      <= {1'b0, div_r};
        fq_r        <= (div_q > W'(1)) ? 17'd0 : 17'(div_q[0]);
        ratio_q_r   <= (div_q > W'(1)) ? 2'd2 : {1'b0, div_q[0]};
      end else if (frac_busy_r) begin
        if (ftrial >= {1'b0, den_r}) begin
          frem_r <= ftrial - {1'b0, den_r};
          fq_r   <= {fq_r[15:0], 1'b1};
        end else begin
          frem_r <= ftrial;
          fq_r   <= {fq_r[15:0], 1'b0};
        end
        fcnt_r <= fcnt_r - 1'b1;
        if (fcnt_r == 5'd1) begin
          frac_busy_r <= 1'b0;
          frac_done_r <= 1'b1;
        end
      end
    end
  end

  // window value, saturation and component total
  logic [16:0] wmag;
  always_comb begin
    if (ratio_q_r == 2'd2 || fq_r > swm_pkg::Q16_ONE) wmag = swm_pkg::Q16_ONE;
    else wmag = fq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r       <= '0;
      wcnt_r      <= '0;
      comp_busy_r <= 1'b0;
      out_r       <= '0;
    end else begin
      if (frac_done_r) begin
        w_r <= neg_r ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
        if (wcnt_r < swm_pkg::WCNT_W'(swm_pkg::MAX_WINDOWS)) begin
          tot_r  <= tot_r + swm_pkg::TOT_W'(neg_r ? -$signed({1'b0, wmag})
                                                  : $signed({1'b0, wmag}));
          wcnt_r <= wcnt_r + 1'b1;
        end
      end
      if (cmd.comp_start) begin
        comp_busy_r <= 1'b1;
        tot_neg_r   <= tot_r[swm_pkg::TOT_W-1];
      end else if (comp_busy_r && div_done) begin
        comp_busy_r <= 1'b0;
        comp_r      <= tot_neg_r ? -$signed(div_q[17:0]) : $signed(div_q[17:0]);
      end
      if (cmd.out_load) begin
        out_r <= {3'd0, cend_r, cend_r ? comp_r : 18'sd0, w_r};
        if (cend_r) begin
          tot_r  <= '0;
          wcnt_r <= '0;
        end
      end
    end
  end

  assign sts.div_done = div_done | frac_done_r;
  assign out_word = out_r;

endmodule

FILE: design/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: accumulate, then walk the window through the divide chain.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               window_end,
  input  logic               component_end,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  swm_pkg::swm_sts_t  sts,
  output swm_pkg::swm_cmd_t  cmd
);

  swm_pkg::swm_state_t state_r, state_nxt;
  logic [2:0] dcnt_r, dcnt_nxt;
  logic       cend_r, cend_nxt;
  logic       vld_r, vld_nxt;
  logic       entered_r;  // first cycle in the current state
  logic       in_acc;

  assign in_acc = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    cend_nxt  = cend_r;
    unique case (state_r)
      swm_pkg::ST_ACC: if (in_acc && window_end) begin
        state_nxt = swm_pkg::ST_MEAN;
        dcnt_nxt  = 3'd0;
        cend_nxt  = component_end;
      end
      swm_pkg::ST_MEAN: if (sts.div_done) begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 3'd4) state_nxt = swm_pkg::ST_TERM1;
      end
      swm_pkg::ST_TERM1: state_nxt = swm_pkg::ST_TERM2;
      swm_pkg::ST_TERM2: state_nxt = swm_pkg::ST_PROD;
      swm_pkg::ST_PROD:  state_nxt = swm_pkg::ST_RATIO;
      swm_pkg::ST_RATIO: if (sts.div_done) state_nxt = swm_pkg::ST_FRAC;
      swm_pkg::ST_FRAC:  if (sts.div_done)
        state_nxt = cend_r ? swm_pkg::ST_COMP : swm_pkg::ST_OUT;
      swm_pkg::ST_COMP:  if (sts.div_done) state_nxt = swm_pkg::ST_OUT;
      swm_pkg::ST_OUT:   if (!vld_r || out_tready) state_nxt = swm_pkg::ST_ACC;
      default:           state_nxt = swm_pkg::ST_ACC;
    endcase
  end

  // outputs; divides start once their operands are registered
  always_comb begin
    cmd = '0;
    in_tready = (state_r == swm_pkg::ST_ACC);
    cmd.acc = in_acc;
    cmd.mean_start  = (state_r == swm_pkg::ST_MEAN) && entered_r;
    cmd.term1       = (state_r == swm_pkg::ST_TERM1);
    cmd.term2       = (state_r == swm_pkg::ST_TERM2);
    cmd.prod        = (state_r == swm_pkg::ST_PROD);
    cmd.ratio_start = (state_r == swm_pkg::ST_RATIO) && entered_r;
    cmd.frac        = (state_r == swm_pkg::ST_RATIO) && sts.div_done;
    cmd.comp_start  = (state_r == swm_pkg::ST_COMP) && entered_r;
    cmd.out_load    = (state_r == swm_pkg::ST_OUT) && (!vld_r || out_tready);
    cmd.out_clear   = vld_r && out_tready;
    vld_nxt = vld_r;
    if (cmd.out_clear) vld_nxt = 1'b0;
    if (cmd.out_load)  vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= swm_pkg::ST_ACC;
      dcnt_r    <= '0;
      cend_r    <= 1'b0;
      vld_r     <= 1'b0;
      entered_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dcnt_r    <= dcnt_nxt;
      cend_r    <= cend_nxt;
      vld_r     <= vld_nxt;
      entered_r <= (state_nxt != state_r);
    end
  end

  assign out_tvalid = vld_r;

endmodule

FILE: design/ssim_window_metric.sv
// ----------------------------------------------------------------------------
// ssim_window_metric
// Per-window SSIM of 8-bit pixel pairs with a running component mean.
// ----------------------------------------------------------------------------
// Pixel words are taken one per cycle while a window fills. After the last
// word of a window the input is held off for five mean divides and one ratio
// divide on one shared radix-2 divider, the term and product steps, the
// fraction bits and the load of the output register, plus the component
// mean divide at a component end. The result is valid in the same cycle as
// the input reopens; a result still waiting on the output holds the next
// window only when that window's own result is ready to load.
module ssim_window_metric (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] pixel_ref, [15:8] pixel_test
  input  logic [1:0]  in_tuser,   // [0] window_end, [1] component_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [17:0] window_ssim, [35:18] component_ssim,
                                  // [36] component_done
);

  swm_pkg::swm_cmd_t cmd;
  swm_pkg::swm_sts_t sts;

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .window_end   (in_tuser[0]),
    .component_end(in_tuser[1]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sts          (sts),
    .cmd          (cmd)
  );

  swm_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_ref    (in_tdata[7:0]),
    .pixel_test   (in_tdata[15:8]),
    .component_end(in_tuser[1]),
    .out_word     (out_tdata)
  );

endmodule

FILE: tb/ssim_window_metric_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssim_window_metric_tb
// Self-checking bench for the SSIM window metric: a directed table of pixel
// words, an overrun window and random windows, with every result compared
// against an in-bench SSIM predictor, random idling on both sides and one
// long output hold-off.
// ----------------------------------------------------------------------------
module ssim_window_metric_tb;

  localparam int NUM_RAND   = 320;
  localparam int DRAIN_CYC  = 600;
  localparam int IDLE_LIMIT = 20000;

  // lowest field in the lowest bits
  typedef struct packed {
    logic               component_done;
    logic signed [17:0] component_ssim;
    logic signed [17:0] window_ssim;
  } ssim_res_t;

  typedef struct {
    logic [7:0] pix_ref;
    logic [7:0] pix_test;
    logic       wend;
    logic       cend;
    logic       has_exp;  // typed-in expectation present
    logic signed [17:0] exp_win;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  ssim_window_metric uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // [7:0] pixel_ref, [15:8] pixel_test
    .in_tuser(in_tuser),   // [0] window_end, [1] component_end
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)  // [17:0] window_ssim, [35:18] component_ssim, [36] done
  );

  // predictor state
  longint unsigned acc_r, acc_t, acc_rr, acc_tt, acc_rt;
  int unsigned     acc_n;
  longint          comp_total;
  int unsigned     comp_windows;

  ssim_res_t expected_q[$];
  int  err_count;
  int  idle_cycles;
  bit  last_phase;
  bit  hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // window SSIM, Q.16, saturated
  function automatic longint window_ssim_q16();
    longint unsigned n, num, den, q, r;
    longint a1, a2, m1, m2, mc, v1, v2, cov, ta, tb, tc, te;
    bit neg;
    n  = acc_n ? acc_n : 1;
    a1 = acc_r / n;  a2 = acc_t / n;
    m1 = acc_rr / n; m2 = acc_tt / n; mc = acc_rt / n;
    v1 = m1 - a1 * a1; v2 = m2 - a2 * a2; cov = mc - a1 * a2;
    ta = 800 * a1 * a2 + longint'(swm_pkg::C1_X400);
    tb = 800 * cov + longint'(swm_pkg::C2_X400);
    tc = 400 * (a1 * a1 + a2 * a2) + longint'(swm_pkg::C1_X400);
    te = 400 * (v1 + v2) + longint'(swm_pkg::C2_X400);
    neg = tb < 0;
    if (te < 1) te = 1;
    num = longint'(ta) * (neg ? -tb : tb);
    den = longint'(tc) * te;
    q = num / den;
    r = num % den;
    if (q > 1) q = swm_pkg::Q16_ONE;
    else begin
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      if (q > swm_pkg::Q16_ONE) q = swm_pkg::Q16_ONE;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // advance the predictor by one accepted pixel word
  task automatic predict_word(input logic [7:0] pr, input logic [7:0] pt,
                              input logic we, input logic ce);
    longint w, comp;
    longint unsigned mag;
    ssim_res_t res;
    comp = 0;
    if (acc_n < swm_pkg::MAX_PIX) begin
      acc_r += pr; acc_t += pt;
      acc_rr += pr * pr; acc_tt += pt * pt; acc_rt += pr * pt;
      acc_n++;
    end
    if (we) begin
      w = window_ssim_q16();
      acc_r = 0; acc_t = 0; acc_rr = 0; acc_tt = 0; acc_rt = 0; acc_n = 0;
      if (comp_windows < swm_pkg::MAX_WINDOWS) begin
        comp_total += w;
        comp_windows++;
      end
      if (ce) begin
        mag  = comp_total < 0 ? -comp_total : comp_total;
        comp = mag / (comp_windows ? comp_windows : 1);
        if (comp_total < 0) comp = -comp;
        comp_total = 0;
        comp_windows = 0;
      end
      res.window_ssim    = w[17:0];
      res.component_ssim = comp[17:0];
      res.component_done = ce;
      expected_q.push_back(res);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    ssim_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[36:0];
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: win exp %0d got %0d, comp exp %0d got %0d, %s %b got %b",
                     want.window_ssim, got.window_ssim, want.component_ssim,
                     got.component_ssim, "done exp", want.component_done,
                     got.component_done);
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ssim_window_metric_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end else if (!last_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // drive one word, waiting for acceptance
  task automatic send_word(input logic [7:0] pr, input logic [7:0] pt,
                           input logic we, input logic ce);
    int n;
    if (!last_phase && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pt, pr};
    in_tuser  <= {ce, we};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(pr, pt, we, ce);
  endtask

  stim_row_t dir_tab[$];

  function automatic stim_row_t row(input int pr, input int pt, input bit we,
                                    input bit ce, input bit he = 0,
                                    input int ew = 0);
    stim_row_t s;
    s.pix_ref = 8'(pr); s.pix_test = 8'(pt); s.wend = we; s.cend = ce;
    s.has_exp = he; s.exp_win = 18'(ew);
    return s;
  endfunction

  initial begin
    int len, wins, lim;
    ssim_res_t tail;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    err_count = 0;
    idle_cycles = 0;
    last_phase = 0;
    hold_off = 0;
    acc_r = 0; acc_t = 0; acc_rr = 0; acc_tt = 0; acc_rt = 0; acc_n = 0;
    comp_total = 0; comp_windows = 0;

    // directed: single-pixel windows of identical pixels give exactly one
    dir_tab.push_back(row(0, 0, 1, 0, 1, 65536));
    dir_tab.push_back(row(255, 255, 1, 0, 1, 65536));
    dir_tab.push_back(row(0, 255, 1, 1));
    dir_tab.push_back(row(255, 0, 0, 1));      // stray component end
    dir_tab.push_back(row(0, 255, 0, 0));
    dir_tab.push_back(row(255, 0, 0, 0));
    dir_tab.push_back(row(0, 255, 1, 0));      // anticorrelated window
    dir_tab.push_back(row(170, 85, 0, 0));
    dir_tab.push_back(row(85, 170, 1, 1));
    dir_tab.push_back(row(128, 128, 1, 1, 1, 65536));
    dir_tab.push_back(row(1, 254, 0, 0));
    dir_tab.push_back(row(254, 1, 1, 1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp) begin
        send_word(dir_tab[i].pix_ref, dir_tab[i].pix_test,
                  dir_tab[i].wend, dir_tab[i].cend);
        if (dir_tab[i].wend && expected_q.size() > 0) begin
          tail = expected_q[$];
          if (tail.window_ssim !== dir_tab[i].exp_win) begin
            err_count++;
            if (err_count <= 10)
              $display("row %0d: predictor %0d, table %0d", i,
                       tail.window_ssim, dir_tab[i].exp_win);
          end
        end
      end else
        send_word(dir_tab[i].pix_ref, dir_tab[i].pix_test,
                  dir_tab[i].wend, dir_tab[i].cend);
    end

    // overrun window: full window plus extra pixels
    for (int i = 0; i < swm_pkg::MAX_PIX + 4; i++)
      send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                i == swm_pkg::MAX_PIX + 3, 1'b0);

    // random windows, mostly small; long hold-off early on
    wins = 0;
    for (int items = 0; items < NUM_RAND; ) begin
      int base_r, base_t, spread;
      if (wins == 3) hold_off = 1'b1;
      if (items > NUM_RAND * 3 / 4) last_phase = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
      base_r = $urandom_range(0, 255);
      base_t = $urandom_range(0, 255);
      spread = $urandom_range(0, 255);
      for (int k = 0; k < len; k++) begin
        int pr, pt;
        pr = base_r + $urandom_range(0, spread) - spread / 2;
        pt = ($urandom_range(0, 1) ? pr : base_t) + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 7) == 0) pr = $urandom_range(0, 255);
        if ($urandom_range(0, 7) == 0) pt = $urandom_range(0, 255);
        pr = pr < 0 ? 0 : (pr > 255 ? 255 : pr);
        pt = pt < 0 ? 0 : (pt > 255 ? 255 : pt);
        send_word(8'(pr), 8'(pt), k == len - 1,
                  (k == len - 1) ? ($urandom_range(0, 3) == 0)
                                 : ($urandom_range(0, 15) == 0));
      end
      items += len;
      wins++;
    end
    send_word(8'd0, 8'd0, 1'b1, 1'b1);
    in_tvalid <= 1'b0;

    lim = 0;
    while (expected_q.size() != 0 && lim < 100000) begin
      @(posedge clk);
      lim++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0)
      $display("ssim_window_metric_tb: done, clean");
    else
      $display("ssim_window_metric_tb: done, errors");
    $finish;
  end

endmodule
